// File: rtl/core/rwcm_pkg.sv
// package for the radius weighted cell matcher
// types, constants and command codes shared by rwcm_front, rwcm_back and the top level
package rwcm_pkg;

    localparam int CELL_DEPTH_DEF = 1024;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_CELL_SZ  = 3'd2,
        REG_RADIUS   = 3'd3,
        REG_MIN_CONF = 3'd4,
        REG_GRID_VLD = 3'd5
    } t_reg;

    localparam logic [1:0] SRC_NONE  = 2'd0;
    localparam logic [1:0] SRC_BIM   = 2'd1;
    localparam logic [1:0] SRC_SLAM  = 2'd2;
    localparam logic [1:0] SRC_CLOUD = 2'd3;

    localparam logic signed [17:0] W_MINUS_ONE = -18'sd65536;
    localparam logic signed [17:0] W_ONE       = 18'sd65536;

    // one queued item, front to back
    typedef struct packed {
        t_cmd               cmd;
        logic [15:0]        col;
        logic [15:0]        row;
        logic signed [17:0] w_total;
        logic signed [17:0] w_model;
        logic signed [17:0] w_map;
        logic signed [17:0] w_scan;
        logic [15:0]        tag;
        logic signed [23:0] px;
        logic signed [23:0] py;
        logic signed [23:0] pz;
        logic               pvalid;
    } t_item;

    typedef struct packed {
        logic               localized;
        logic signed [34:0] mx;
        logic signed [34:0] my;
        logic signed [23:0] mz;
        logic [15:0]        tag;
        logic [16:0]        conf;
        logic [1:0]         src;
        logic               ovf;
    } t_result;

    // row of the cell memory: tag, scan, map, model, total, row, col
    localparam int ROW_W = 16 + 18 * 4 + 32;

endpackage

// File: rtl/core/rwcm_ram.sv
// generic single port write, single port read ram with registered read
// no package dependency
module rwcm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/core/rwcm_front.sv
// front end: accepts input beats, drops no-ops, queues items for the back end
// depends on rwcm_pkg
module rwcm_front
    import rwcm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_ready,
    output t_item o_item
);
    // two-entry queue
    t_item      r_q [2];
    logic [1:0] r_cnt;
    logic       r_rd;
    logic       push, pop, keep;

    assign o_ready = (r_cnt != 2'd2);
    assign keep    = (i_item.cmd != CMD_NOP);
    assign push    = i_valid && o_ready && keep;
    assign o_valid = (r_cnt != 2'd0);
    assign pop     = o_valid && i_ready;
    assign o_item  = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 1'b0;
        end else begin
            if (push) begin
                r_q[r_rd ^ r_cnt[0]] <= i_item;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

`ifndef SYNTHESIS
    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 |-> !o_ready) else $error("full queue took a beat");
    a_nop_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && !keep && !pop) |=> $stable(r_cnt))
        else $error("no-op entered queue");
`endif
endmodule

// File: rtl/core/rwcm_back.sv
// back end: cell table, scan over stored cells, result register
// depends on rwcm_pkg and rwcm_ram
module rwcm_back
    import rwcm_pkg::*;
#(
    parameter int CELL_DEPTH = CELL_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  t_item              i_item,
    input  logic signed [23:0] i_org_x,
    input  logic signed [23:0] i_org_y,
    input  logic [15:0]        i_cell_sz,
    input  logic [15:0]        i_radius,
    input  logic [16:0]        i_min_conf,
    input  logic               i_grid_vld,
    output logic               o_valid,
    input  logic               i_ready,
    output t_result            o_res
);
    localparam int AW = (CELL_DEPTH > 1) ? $clog2(CELL_DEPTH) : 1;
    localparam int CW = $clog2(CELL_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(CELL_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_FETCH, S_WAIT, S_FIN
    } t_state;

    t_state              r_state;
    logic [CW-1:0]       r_count;
    logic                r_ovf;
    logic [CW-1:0]       r_idx;
    logic                r_rvalid;   // ram data belongs to r_pidx
    logic [AW-1:0]       r_pidx;
    logic                r_found;
    logic signed [17:0]  r_best_w;
    logic [AW-1:0]       r_best;
    t_item               r_q;
    logic                r_ovalid;
    t_result             r_res;
    // distance pipe
    logic                r_dv;
    logic signed [17:0]  r_dw;
    logic [AW-1:0]       r_didx;
    logic [35:0]         r_ax, r_ay;
    logic                r_dnear;
    logic                r_sv;
    logic signed [17:0]  r_sw;
    logic [AW-1:0]       r_sidx;
    logic [71:0]         r_sq;
    logic                r_sin;

    logic                we;
    logic [AW-1:0]       raddr;
    logic [ROW_W-1:0]    wrow, rrow;
    logic [15:0]         f_col, f_row, f_tag;
    logic signed [17:0]  f_wt, f_wm, f_ws, f_wc;
    logic signed [35:0]  cx, cy, px2, py2, dx, dy;
    logic [35:0]         ax, ay;
    logic [17:0]         r2;
    logic [35:0]         sqx, sqy, r2sq;
    logic [16:0]         clamped;
    logic                fin_go;
    t_result             n_res;

    assign wrow = {i_item.tag, i_item.w_scan, i_item.w_map, i_item.w_model,
                   i_item.w_total, i_item.row, i_item.col};
    assign {f_tag, f_wc, f_ws, f_wm, f_wt, f_row, f_col} = rrow;

    // a waiting result only holds back the next query at its last step
    assign o_ready = (r_state == S_IDLE);
    assign we = i_valid && o_ready && (i_item.cmd == CMD_APPEND) && (r_count < DEPTH_C);
    assign raddr = (r_state == S_FETCH || r_state == S_WAIT || r_state == S_FIN)
                 ? r_best : r_idx[AW-1:0];
    assign fin_go = (r_state == S_FIN) && (!r_ovalid || i_ready);

    rwcm_ram #(.WIDTH(ROW_W), .DEPTH(CELL_DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(r_count[AW-1:0]),
        .i_wdata(wrow),
        .i_raddr(raddr),
        .o_rdata(rrow)
    );

    // centre in half mm: 2*origin + (2*index+1)*size
    assign cx  = 36'(signed'({i_org_x, 1'b0}))
               + 36'(signed'({1'b0, 17'({f_col, 1'b1}) * 33'(i_cell_sz)}));
    assign cy  = 36'(signed'({i_org_y, 1'b0}))
               + 36'(signed'({1'b0, 17'({f_row, 1'b1}) * 33'(i_cell_sz)}));
    assign px2 = 36'(signed'({r_q.px, 1'b0}));
    assign py2 = 36'(signed'({r_q.py, 1'b0}));
    assign dx  = cx - px2;
    assign dy  = cy - py2;
    assign ax  = dx[35] ? 36'(-dx) : 36'(dx);
    assign ay  = dy[35] ? 36'(-dy) : 36'(dy);
    assign r2  = {1'b0, i_radius, 1'b0};
    assign sqx = r_ax[17:0] * r_ax[17:0];
    assign sqy = r_ay[17:0] * r_ay[17:0];
    assign r2sq = r2 * r2;
    assign clamped = (r_best_w > W_ONE) ? 17'd65536 : 17'(r_best_w);

    // result of the finished query
    always_comb begin
        n_res     = '0;
        n_res.ovf = r_ovf;
        n_res.src = SRC_NONE;
        if (r_found && r_best_w > 18'sd0) begin
            n_res.conf = clamped;
            if (clamped >= i_min_conf) begin
                n_res.localized = 1'b1;
                n_res.mx  = 35'(cx);
                n_res.my  = 35'(cy);
                n_res.mz  = r_q.pz;
                n_res.tag = f_tag;
                if (f_wm >= f_ws && f_wm >= f_wc && f_tag != 16'd0) begin
                    n_res.src = SRC_BIM;
                end else if (f_ws >= f_wc) begin
                    n_res.src = SRC_SLAM;
                end else begin
                    n_res.src = SRC_CLOUD;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_ovalid <= 1'b0;
            r_rvalid <= 1'b0;
            r_dv     <= 1'b0;
            r_sv     <= 1'b0;
        end else begin
            if (fin_go) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            // scan pipe: ram -> abs diff -> squares -> compare
            r_dv    <= r_rvalid;
            r_dw    <= f_wt;
            r_didx  <= r_pidx;
            r_ax    <= ax;
            r_ay    <= ay;
            r_dnear <= (ax <= 36'(r2)) && (ay <= 36'(r2));
            r_sv    <= r_dv;
            r_sw    <= r_dw;
            r_sidx  <= r_didx;
            r_sq    <= 72'(sqx) + 72'(sqy);
            r_sin   <= r_dnear;
            r_rvalid <= (r_state == S_SCAN) && (r_idx < r_count);
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_q      <= i_item;
                        r_idx    <= '0;
                        r_found  <= 1'b0;
                        r_best_w <= W_MINUS_ONE;
                        r_best   <= '0;
                        unique case (i_item.cmd)
                            CMD_CLEAR: r_count <= '0;
                            CMD_APPEND: begin
                                if (r_count < DEPTH_C) begin
                                    r_count <= r_count + 1'b1;
                                end else begin
                                    r_ovf <= 1'b1;
                                end
                            end
                            CMD_QUERY: begin
                                if (i_item.pvalid && i_grid_vld && r_count != '0) begin
                                    r_state <= S_SCAN;
                                end else begin
                                    r_state <= S_FIN;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_SCAN: begin
                    if (r_idx < r_count) begin
                        r_pidx   <= r_idx[AW-1:0];
                        r_idx    <= r_idx + 1'b1;
                    end else if (!r_rvalid && !r_dv && !r_sv) begin
                        r_state <= S_FETCH;
                    end
                end
                S_FETCH: r_state <= S_WAIT;
                S_WAIT:  r_state <= S_FIN;
                S_FIN: begin
                    if (fin_go) begin
                        r_res   <= n_res;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (r_sv && r_sin && (r_sq <= 72'(r2sq)) && (r_sw > r_best_w)) begin
                r_best_w <= r_sw;
                r_best   <= r_sidx;
                r_found  <= 1'b1;
            end
        end
    end

    assign o_valid = r_ovalid;
    assign o_res   = r_res;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C) else $error("cell count above depth");
    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |=> r_ovf) else $error("overflow flag dropped");
    a_busy_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !o_ready) else $error("item taken while busy");
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !i_ready) |=> r_ovalid) else $error("result lost");
`endif
endmodule

// File: rtl/core/radius_weighted_cell_matcher_top.sv
// top level of the radius weighted cell matcher
// depends on rwcm_pkg, rwcm_front, rwcm_back, rwcm_ram
//
//  channel   | direction | beat contents
//  s_axis    | in        | command item (tdata fields below)
//  m_axis    | out       | one result per query
//  cfg       | in        | register index and write data
//
// an append or clear is taken while the back end is idle; a query walks the
// cell memory through its single read port, one cell a cycle. reset is
// synchronous active low and empties the table (count and overflow flag);
// memory contents are not cleared. the front queue takes up to two beats
// while the back end scans or a result waits on m_axis.
module radius_weighted_cell_matcher_top
    import rwcm_pkg::*;
#(
    parameter int CELL_DEPTH = CELL_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // command[1:0], cell_col, cell_row, cell_weight, model_weight,
    // mapping_weight, scan_weight, model_tag, point_x, point_y, point_z,
    // point_valid (bit 194), zero fill to 200
    input  logic [199:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // localized, match_x_half_mm, match_y_half_mm, match_z_mm, match_tag,
    // confidence, source_code, table_overflow (bit 130), zero fill to 136
    output logic [135:0] m_axis_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [23:0]  i_cfg_data
);
    t_item   in_item, q_item;
    t_result res;
    logic    q_valid, q_ready;

    logic signed [23:0] r_org_x, r_org_y;
    logic [15:0]        r_cell_sz, r_radius;
    logic [16:0]        r_min_conf;
    logic               r_grid_vld;

    // unpack input beat
    assign in_item.cmd     = t_cmd'(s_axis_tdata[1:0]);
    assign in_item.col     = s_axis_tdata[17:2];
    assign in_item.row     = s_axis_tdata[33:18];
    assign in_item.w_total = s_axis_tdata[51:34];
    assign in_item.w_model = s_axis_tdata[69:52];
    assign in_item.w_map   = s_axis_tdata[87:70];
    assign in_item.w_scan  = s_axis_tdata[105:88];
    assign in_item.tag     = s_axis_tdata[121:106];
    assign in_item.px      = s_axis_tdata[145:122];
    assign in_item.py      = s_axis_tdata[169:146];
    assign in_item.pz      = s_axis_tdata[193:170];
    assign in_item.pvalid  = s_axis_tdata[194];

    // config registers, always writable
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x    <= '0;
            r_org_y    <= '0;
            r_cell_sz  <= 16'd50;
            r_radius   <= 16'd500;
            r_min_conf <= 17'd32768;
            r_grid_vld <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ORIGIN_X: r_org_x    <= i_cfg_data;
                REG_ORIGIN_Y: r_org_y    <= i_cfg_data;
                REG_CELL_SZ:  r_cell_sz  <= i_cfg_data[15:0];
                REG_RADIUS:   r_radius   <= i_cfg_data[15:0];
                REG_MIN_CONF: r_min_conf <= i_cfg_data[16:0];
                REG_GRID_VLD: r_grid_vld <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    rwcm_front u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid),
        .o_ready(s_axis_tready),
        .i_item (in_item),
        .o_valid(q_valid),
        .i_ready(q_ready),
        .o_item (q_item)
    );

    rwcm_back #(.CELL_DEPTH(CELL_DEPTH)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (q_valid),
        .o_ready   (q_ready),
        .i_item    (q_item),
        .i_org_x   (r_org_x),
        .i_org_y   (r_org_y),
        .i_cell_sz (r_cell_sz),
        .i_radius  (r_radius),
        .i_min_conf(r_min_conf),
        .i_grid_vld(r_grid_vld),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_res     (res)
    );

    // pack result beat
    assign m_axis_tdata = {5'd0, res.ovf, res.src, res.conf, res.tag, res.mz,
                           res.my, res.mx, res.localized};
endmodule

// File: tb/radius_weighted_cell_matcher_top_tb.sv
// self-checking testbench for radius_weighted_cell_matcher_top
// depends on rwcm_pkg and the rtl/core sources; predicts every query result in-line
module radius_weighted_cell_matcher_top_tb;
    import rwcm_pkg::*;

    localparam int DEPTH        = CELL_DEPTH_DEF;
    localparam int SETTLE       = 40;      // append/clear have no result, let them finish
    localparam int TAIL_CYCLES  = DEPTH + 64;
    localparam int STALL_LIMIT  = 40000;   // cycles with no beat on any channel
    localparam logic [2:0] REG_UNUSED = 3'd6;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [199:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [135:0] m_axis_tdata;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [2:0]   i_cfg_index;
    logic [23:0]  i_cfg_data;

    radius_weighted_cell_matcher_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // predictor copy of registers and cell table
    longint      grid_ox, grid_oy;
    int unsigned grid_size, grid_radius, grid_min_conf;
    bit          grid_ok;
    logic [15:0]        tbl_col [DEPTH];
    logic [15:0]        tbl_row [DEPTH];
    int                 tbl_w   [DEPTH];
    int                 tbl_wm  [DEPTH];
    int                 tbl_ws  [DEPTH];
    int                 tbl_wc  [DEPTH];
    logic [15:0]        tbl_tag [DEPTH];
    int unsigned        tbl_count;
    bit                 tbl_overflow;

    t_item   beat_queue[$];        // items still to be sent
    t_result pending_results[$];   // predicted query results, oldest first
    t_item   item_on_bus;
    int      send_idle_pct, recv_idle_pct;
    int      fail_count;
    int      quiet_cycles;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint centre_half_mm(longint org, logic [15:0] idx);
        return 2 * org + (2 * longint'(idx) + 1) * longint'(grid_size);
    endfunction

    function automatic longint abs_l(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // adds one item to the tail of the send queue
    function automatic void queue_beat(t_item it);
        beat_queue.insert(beat_queue.size(), it);
    endfunction

    // applies one accepted beat to the predicted table, queues a result for queries
    function automatic void match_detection(t_item it);
        longint  px2, py2, cx, cy, ax, ay, r2;
        int      best_w;
        int      best;
        bit      found;
        int      clamped;
        t_result res;
        res = '0;
        case (it.cmd)
            CMD_CLEAR: tbl_count = 0;
            CMD_APPEND: begin
                if (tbl_count >= DEPTH) begin
                    tbl_overflow = 1'b1;
                end else begin
                    tbl_col[tbl_count] = it.col;
                    tbl_row[tbl_count] = it.row;
                    tbl_w[tbl_count]   = int'(it.w_total);
                    tbl_wm[tbl_count]  = int'(it.w_model);
                    tbl_ws[tbl_count]  = int'(it.w_map);
                    tbl_wc[tbl_count]  = int'(it.w_scan);
                    tbl_tag[tbl_count] = it.tag;
                    tbl_count++;
                end
            end
            CMD_QUERY: begin
                px2    = 2 * longint'(it.px);
                py2    = 2 * longint'(it.py);
                r2     = 2 * longint'(grid_radius);
                best_w = -65536;
                best   = 0;
                found  = 1'b0;
                if (it.pvalid && grid_ok) begin
                    for (int i = 0; i < tbl_count; i++) begin
                        ax = abs_l(centre_half_mm(grid_ox, tbl_col[i]) - px2);
                        ay = abs_l(centre_half_mm(grid_oy, tbl_row[i]) - py2);
                        // coarse box test first keeps the squares small
                        if (ax <= r2 && ay <= r2 && ax * ax + ay * ay <= r2 * r2
                            && tbl_w[i] > best_w) begin
                            best_w = tbl_w[i];
                            best   = i;
                            found  = 1'b1;
                        end
                    end
                end
                if (found && best_w > 0) begin
                    clamped  = (best_w > 65536) ? 65536 : best_w;
                    res.conf = clamped[16:0];
                    if (clamped >= int'(grid_min_conf)) begin
                        cx = centre_half_mm(grid_ox, tbl_col[best]);
                        cy = centre_half_mm(grid_oy, tbl_row[best]);
                        res.localized = 1'b1;
                        res.mx  = cx[34:0];
                        res.my  = cy[34:0];
                        res.mz  = it.pz;
                        res.tag = tbl_tag[best];
                        if (tbl_wm[best] >= tbl_ws[best] && tbl_wm[best] >= tbl_wc[best]
                            && tbl_tag[best] != 0)
                            res.src = SRC_BIM;
                        else if (tbl_ws[best] >= tbl_wc[best])
                            res.src = SRC_SLAM;
                        else
                            res.src = SRC_CLOUD;
                    end
                end
                res.ovf = tbl_overflow;
                pending_results.insert(pending_results.size(), res);
            end
            default: ;   // unused command does nothing
        endcase
    endfunction

    function automatic void apply_register(logic [2:0] idx, logic [23:0] val);
        case (idx)
            REG_ORIGIN_X: grid_ox       = longint'($signed(val));
            REG_ORIGIN_Y: grid_oy       = longint'($signed(val));
            REG_CELL_SZ:  grid_size     = val[15:0];
            REG_RADIUS:   grid_radius   = val[15:0];
            REG_MIN_CONF: grid_min_conf = val[16:0];
            REG_GRID_VLD: grid_ok       = val[0];
            default: ;
        endcase
    endfunction

    // tdata fields from the lowest bit; fill bits above the valid flag stay zero
    function automatic logic [199:0] pack_item(t_item it);
        logic [199:0] d;
        d = '0;
        d[1:0]     = it.cmd;
        d[17:2]    = it.col;
        d[33:18]   = it.row;
        d[51:34]   = it.w_total;
        d[69:52]   = it.w_model;
        d[87:70]   = it.w_map;
        d[105:88]  = it.w_scan;
        d[121:106] = it.tag;
        d[145:122] = it.px;
        d[169:146] = it.py;
        d[193:170] = it.pz;
        d[194]     = it.pvalid;
        return d;
    endfunction

    function automatic t_item mk_cmd(t_cmd c);
        t_item it;
        it     = '0;
        it.cmd = c;
        return it;
    endfunction

    function automatic t_item mk_append(int col, int row, int w, int wm, int ws, int wc,
                                        int tag);
        t_item it;
        it = mk_cmd(CMD_APPEND);
        it.col = col[15:0];  it.row = row[15:0];
        it.w_total = w[17:0]; it.w_model = wm[17:0]; it.w_map = ws[17:0];
        it.w_scan = wc[17:0]; it.tag = tag[15:0];
        return it;
    endfunction

    function automatic t_item mk_query(longint x, longint y, longint z, bit v);
        t_item it;
        it = mk_cmd(CMD_QUERY);
        it.px = x[23:0]; it.py = y[23:0]; it.pz = z[23:0]; it.pvalid = v;
        return it;
    endfunction

    function automatic t_item random_item();
        t_item        it;
        int           sel, col, row;
        logic [223:0] noise;
        sel = $urandom_range(99);
        col = $urandom_range(15);
        row = $urandom_range(15);
        if (sel < 45) begin
            // weights in a few coarse steps so ties and source ties happen
            it = mk_append(col, row, $urandom_range(8) * 16384 - 32768,
                           $urandom_range(3) * 20000, $urandom_range(3) * 20000,
                           $urandom_range(3) * 20000,
                           ($urandom_range(3) == 0) ? 0 : $urandom_range(65535));
        end else if (sel < 78) begin
            // detection near a likely cell centre
            it = mk_query(grid_ox + col * grid_size + $urandom_range(2 * grid_radius + 2)
                          - grid_radius,
                          grid_oy + row * grid_size + $urandom_range(2 * grid_radius + 2)
                          - grid_radius,
                          $urandom, $urandom_range(9) != 0);
        end else if (sel < 83) begin
            it = mk_cmd(CMD_CLEAR);
        end else if (sel < 86) begin
            it = mk_cmd(CMD_NOP);
        end else begin
            // noise: every field over its whole range
            noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            it = noise[$bits(t_item)-1:0];
            if (it.cmd == CMD_CLEAR && $urandom_range(1)) it.cmd = CMD_QUERY;
        end
        return it;
    endfunction

    // driver: one nonblocking update per signal per edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                match_detection(item_on_bus);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (beat_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    item_on_bus = beat_queue.pop_front();
                    s_axis_tdata  <= pack_item(item_on_bus);
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result beat with the oldest prediction, plus watchdog
    always @(posedge i_clk) begin
        t_result got, want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            quiet_cycles  <= 0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            if (m_axis_tvalid && m_axis_tready) begin
                got.localized = m_axis_tdata[0];
                got.mx   = m_axis_tdata[35:1];
                got.my   = m_axis_tdata[70:36];
                got.mz   = m_axis_tdata[94:71];
                got.tag  = m_axis_tdata[110:95];
                got.conf = m_axis_tdata[127:111];
                got.src  = m_axis_tdata[129:128];
                got.ovf  = m_axis_tdata[130];
                if (pending_results.size() == 0) begin
                    $error("result beat with no prediction waiting");
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.localized !== want.localized) begin
                        $error("localized exp %0d got %0d", want.localized, got.localized);
                        fail_count++;
                    end
                    if (got.mx !== want.mx) begin
                        $error("match_x_half_mm exp %0d got %0d", want.mx, got.mx);
                        fail_count++;
                    end
                    if (got.my !== want.my) begin
                        $error("match_y_half_mm exp %0d got %0d", want.my, got.my);
                        fail_count++;
                    end
                    if (got.mz !== want.mz) begin
                        $error("match_z_mm exp %0d got %0d", want.mz, got.mz);
                        fail_count++;
                    end
                    if (got.tag !== want.tag) begin
                        $error("match_tag exp %0d got %0d", want.tag, got.tag);
                        fail_count++;
                    end
                    if (got.conf !== want.conf) begin
                        $error("confidence exp %0d got %0d", want.conf, got.conf);
                        fail_count++;
                    end
                    if (got.src !== want.src) begin
                        $error("source_code exp %0d got %0d", want.src, got.src);
                        fail_count++;
                    end
                    if (got.ovf !== want.ovf) begin
                        $error("table_overflow exp %0d got %0d", want.ovf, got.ovf);
                        fail_count++;
                    end
                end
            end
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // register write, only called while the block is idle
    task automatic write_reg(logic [2:0] idx, logic [23:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        apply_register(idx, val);
        i_cfg_valid <= 1'b0;
    endtask

    // sender holds off until every beat is out and every result is back
    task automatic drain();
        while (beat_queue.size() > 0 || s_axis_tvalid) @(posedge i_clk);
        while (pending_results.size() > 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic random_settings();
        int pick;
        pick = $urandom_range(5);
        write_reg(REG_ORIGIN_X, (pick == 0) ? 24'h800000 : (pick == 1) ? 24'h7fffff
                                : 24'($signed($urandom_range(4000)) - 2000));
        write_reg(REG_ORIGIN_Y, (pick == 1) ? 24'h800000 : (pick == 0) ? 24'h7fffff
                                : 24'($urandom));
        pick = $urandom_range(3);
        write_reg(REG_CELL_SZ, (pick == 0) ? 24'd1 : (pick == 1) ? 24'd65535
                               : (pick == 2) ? 24'd50 : 24'($urandom_range(1, 400)));
        pick = $urandom_range(3);
        write_reg(REG_RADIUS, (pick == 0) ? 24'd1 : (pick == 1) ? 24'd65535
                              : (pick == 2) ? 24'd500 : 24'($urandom_range(1, 2000)));
        pick = $urandom_range(3);
        write_reg(REG_MIN_CONF, (pick == 0) ? 24'd0 : (pick == 1) ? 24'd65536
                                : 24'($urandom_range(65536)));
        write_reg(REG_GRID_VLD, 24'($urandom_range(7) != 0));
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = REG_ORIGIN_X;
        i_cfg_data    = '0;
        fail_count    = 0;
        send_idle_pct = 11;
        recv_idle_pct = 87;
        grid_ox = 0; grid_oy = 0; grid_size = 50; grid_radius = 500;
        grid_min_conf = 32768; grid_ok = 1'b0;
        tbl_count = 0; tbl_overflow = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // grid not valid yet: query is unlocalized
        queue_beat(mk_append(0, 0, 65536, 1, 0, 0, 7));
        queue_beat(mk_query(25, 25, 100, 1'b1));
        drain();
        write_reg(REG_GRID_VLD, 24'd1);
        write_reg(REG_UNUSED, 24'hffffff);            // ignored index
        // empty table query, then a no-op
        queue_beat(mk_cmd(CMD_CLEAR));
        queue_beat(mk_query(25, 25, 1, 1'b1));
        queue_beat(mk_cmd(CMD_NOP));
        // ties: first stored wins; source picks bim and cloud
        queue_beat(mk_append(0, 0, 40000, 9, 9, 9, 3));
        queue_beat(mk_append(1, 0, 40000, 1, 5, 5, 4));
        queue_beat(mk_query(25, 25, -8388608, 1'b0));
        queue_beat(mk_query(25, 25, 8388607, 1'b1));
        queue_beat(mk_append(2, 0, 131071, 9, 1, 5, 0));   // clamp, tag none
        queue_beat(mk_query(125, 25, 5, 1'b1));
        queue_beat(mk_cmd(CMD_CLEAR));
        queue_beat(mk_append(0, 0, 30000, 0, 1, 2, 9));    // low confidence
        queue_beat(mk_query(25, 25, 6, 1'b1));
        queue_beat(mk_cmd(CMD_CLEAR));
        queue_beat(mk_append(0, 0, -65536, 0, 0, 0, 1));   // never chosen
        queue_beat(mk_append(1, 0, -131072, 0, 0, 0, 1));
        queue_beat(mk_append(2, 0, 0, 0, 0, 0, 1));        // chosen, not above zero
        queue_beat(mk_query(25, 25, 7, 1'b1));
        queue_beat(mk_append(65535, 65535, 70000, 0, 0, 0, 65535));
        queue_beat(mk_query(-8388608, 8388607, 8, 1'b1));  // out of range
        drain();

        // random phases under three idling patterns
        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct = (mode == 0) ? 11 : (mode == 1) ? 87 : 0;
            recv_idle_pct = (mode == 0) ? 87 : (mode == 1) ? 11 : 0;
            for (int ph = 0; ph < 4; ph++) begin
                random_settings();
                queue_beat(mk_cmd(CMD_CLEAR));
                for (int k = 0; k < 46; k++)
                    queue_beat(random_item());
                drain();
            end
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
